// File: design/avsfd_pkg.sv
// ----------------------------------------------------------------------------
// avsfd_pkg
// Shared types and constants for the audio/video sync frame delay regulator.
// ----------------------------------------------------------------------------
package avsfd_pkg;

    // timestamp width; now_ms is one bit narrower
    localparam int TIME_BITS = 48;
    localparam int NOW_BITS  = TIME_BITS - 1;

    // only the low 32 bits of any difference are ever looked at
    localparam int DIFF_BITS = 32;

    localparam int PERIOD_BITS = 10;
    localparam int OFFSET_BITS = 16;
    localparam int SLEEP_BITS  = 16;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 10'd40;

    // thresholds
    localparam logic signed [DIFF_BITS+1:0] JITTER_LIMIT = 34'sd5;
    localparam logic signed [DIFF_BITS-1:0] DRIFT_SMALL  = 32'sd50;
    localparam logic signed [DIFF_BITS-1:0] DRIFT_LARGE  = 32'sd500;
    localparam logic signed [3:0]           STEP_SMALL   = 4'sd1;
    localparam logic signed [3:0]           STEP_LARGE   = 4'sd3;
    localparam logic [SLEEP_BITS-1:0]       SLEEP_MAX    = 16'hFFFF;

    // register map, indexed by word address
    typedef enum logic {
        REG_FRAME_PERIOD = 1'b0,
        REG_AV_OFFSET    = 1'b1
    } reg_idx_t;

    // timing state carried from one frame to the next
    typedef struct packed {
        logic                  latched;
        logic [DIFF_BITS-1:0]  last_tick;
        logic [DIFF_BITS-1:0]  start_ofs;   // start video pts minus start tick
        logic [SLEEP_BITS-1:0] sleep;
    } sync_state_t;

endpackage

// File: design/av_sync_frame_delay_regulator_core.sv
// ----------------------------------------------------------------------------
// av_sync_frame_delay_regulator_core
// Works out the wait before the next displayed frame from a/v timestamps.
// ----------------------------------------------------------------------------
// usage
// - s_ channel: one word per displayed frame (now, audio pts, video pts)
// - m_ channel: one word per input word, the updated sleep in ms
// - apb port: frame period at 0x0 (also reloads the sleep value), signed
//   a/v offset at 0x4; write only while no frame is in flight
// - path: an accepted word enters the input register; the update logic then
//   writes the result register when it is empty or being read
// - throughput: one word per cycle while m_ready is held high; the frame update is a single pass of
//   adders and compares between the input register and the state/result
//   registers, so each frame sees the state left by the one before it
// - a stalled m_ready holds the result; the input register still takes one
//   more word, after which s_ready drops until the result drains
// - reset: both word registers empty, period 40, offset 0, sleep 40, start
//   point not latched
// ----------------------------------------------------------------------------
module av_sync_frame_delay_regulator_core (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // apb configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [avsfd_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [avsfd_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [avsfd_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                     pready,
    // frame input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [avsfd_pkg::NOW_BITS-1:0]           s_now_ms,
    input  logic signed [avsfd_pkg::TIME_BITS-1:0]   s_audio_pts_ms,
    input  logic signed [avsfd_pkg::TIME_BITS-1:0]   s_video_pts_ms,
    // result output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [avsfd_pkg::SLEEP_BITS-1:0]         m_sleep_ms
);

    localparam int PB = avsfd_pkg::PERIOD_BITS;
    localparam int OB = avsfd_pkg::OFFSET_BITS;
    localparam int DW = avsfd_pkg::APB_DATA_BITS;

    logic                                   in_vld_reg;
    logic [avsfd_pkg::NOW_BITS-1:0]         now_reg;
    logic signed [avsfd_pkg::TIME_BITS-1:0] apts_reg;
    logic signed [avsfd_pkg::TIME_BITS-1:0] vpts_reg;

    logic                                   out_vld_reg;
    logic [avsfd_pkg::SLEEP_BITS-1:0]       sleep_out_reg;

    logic [PB-1:0]                          period_reg;
    logic signed [OB-1:0]                   offset_reg;

    avsfd_pkg::sync_state_t                 state_reg;
    avsfd_pkg::sync_state_t                 state_next;
    avsfd_pkg::sync_state_t                 step_state;

    logic                                   process;
    logic                                   in_take;
    logic                                   cfg_wr;
    avsfd_pkg::reg_idx_t                    cfg_idx;

    assign process = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || process;
    assign in_take = s_valid && s_ready;

    assign m_valid    = out_vld_reg;
    assign m_sleep_ms = sleep_out_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = avsfd_pkg::reg_idx_t'(paddr[2]);

    avsfd_step u_step (
        .state        (state_reg),
        .frame_period (period_reg),
        .av_offset    (offset_reg),
        .now_ms       (now_reg),
        .audio_pts_ms (apts_reg),
        .video_pts_ms (vpts_reg),
        .state_next   (step_state)
    );

    always_comb begin
        state_next = state_reg;
        if (process) begin
            state_next = step_state;
        end
        // a period write reloads the sleep value
        if (cfg_wr && (cfg_idx == avsfd_pkg::REG_FRAME_PERIOD)) begin
            state_next.sleep = {{(avsfd_pkg::SLEEP_BITS-PB){1'b0}}, pwdata[PB-1:0]};
        end
    end

    always_comb begin
        unique case (cfg_idx)
            avsfd_pkg::REG_FRAME_PERIOD: prdata = {{(DW-PB){1'b0}}, period_reg};
            avsfd_pkg::REG_AV_OFFSET:    prdata = {{(DW-OB){1'b0}}, offset_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            period_reg  <= avsfd_pkg::PERIOD_RESET;
            offset_reg  <= '0;
            state_reg.latched   <= 1'b0;
            state_reg.last_tick <= '0;
            state_reg.start_ofs <= '0;
            state_reg.sleep     <= {{(avsfd_pkg::SLEEP_BITS-PB){1'b0}},
                                    avsfd_pkg::PERIOD_RESET};
        end else begin
            state_reg <= state_next;
            if (in_take) begin
                in_vld_reg <= 1'b1;
            end else if (process) begin
                in_vld_reg <= 1'b0;
            end
            if (process) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    avsfd_pkg::REG_FRAME_PERIOD: period_reg <= pwdata[PB-1:0];
                    avsfd_pkg::REG_AV_OFFSET:    offset_reg <= signed'(pwdata[OB-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            now_reg  <= s_now_ms;
            apts_reg <= s_audio_pts_ms;
            vpts_reg <= s_video_pts_ms;
        end
        if (process) begin
            sleep_out_reg <= step_state.sleep;
        end
    end

endmodule

// File: design/avsfd_step.sv
// ----------------------------------------------------------------------------
// avsfd_step
// Per-frame update: jitter and drift checks, sleep nudge and clamp.
// ----------------------------------------------------------------------------
module avsfd_step (
    input  avsfd_pkg::sync_state_t                   state,
    input  logic [avsfd_pkg::PERIOD_BITS-1:0]        frame_period,
    input  logic signed [avsfd_pkg::OFFSET_BITS-1:0] av_offset,
    input  logic [avsfd_pkg::NOW_BITS-1:0]           now_ms,
    input  logic signed [avsfd_pkg::TIME_BITS-1:0]   audio_pts_ms,
    input  logic signed [avsfd_pkg::TIME_BITS-1:0]   video_pts_ms,
    output avsfd_pkg::sync_state_t                   state_next
);

    localparam int DB = avsfd_pkg::DIFF_BITS;
    localparam int SB = avsfd_pkg::SLEEP_BITS;

    logic [DB-1:0]        now_lo;
    logic [DB-1:0]        vpts_lo;
    logic [DB-1:0]        apts_lo;
    logic [DB-1:0]        off_ext;
    logic [DB-1:0]        tick_diff;
    logic [DB-1:0]        start_ofs;
    logic [DB-1:0]        av_diff;
    logic [DB-1:0]        sc_diff;
    logic signed [DB-1:0] drift;
    logic signed [DB+1:0] jitter;
    logic                 audio_bad;
    logic signed [3:0]    jit_step;
    logic signed [3:0]    drift_step;
    logic signed [SB+1:0] sleep_sum;
    logic [SB-1:0]        sleep_new;

    always_comb begin
        now_lo  = now_ms[DB-1:0];
        vpts_lo = video_pts_ms[DB-1:0];
        apts_lo = audio_pts_ms[DB-1:0];
        off_ext = {{(DB-avsfd_pkg::OFFSET_BITS){av_offset[avsfd_pkg::OFFSET_BITS-1]}},
                   av_offset};

        tick_diff = now_lo - state.last_tick;
        // first frame latches its own start point
        start_ofs = state.latched ? state.start_ofs : (vpts_lo - now_lo);

        av_diff   = apts_lo - vpts_lo - off_ext;
        sc_diff   = start_ofs + now_lo - vpts_lo - off_ext;
        audio_bad = audio_pts_ms[avsfd_pkg::TIME_BITS-1] || (audio_pts_ms == '0);
        drift     = audio_bad ? signed'(sc_diff) : signed'(av_diff);

        jitter = signed'({{2{tick_diff[DB-1]}}, tick_diff})
               - signed'({{(DB+2-avsfd_pkg::PERIOD_BITS){1'b0}}, frame_period});

        jit_step = '0;
        if (jitter > avsfd_pkg::JITTER_LIMIT) begin
            jit_step = -avsfd_pkg::STEP_SMALL;
        end else if (jitter < -avsfd_pkg::JITTER_LIMIT) begin
            jit_step = avsfd_pkg::STEP_SMALL;
        end

        drift_step = '0;
        if (!video_pts_ms[avsfd_pkg::TIME_BITS-1]) begin
            if (drift > avsfd_pkg::DRIFT_LARGE) begin
                drift_step = -avsfd_pkg::STEP_LARGE;
            end else if (drift > avsfd_pkg::DRIFT_SMALL) begin
                drift_step = -avsfd_pkg::STEP_SMALL;
            end else if (drift < -avsfd_pkg::DRIFT_LARGE) begin
                drift_step = avsfd_pkg::STEP_LARGE;
            end else if (drift < -avsfd_pkg::DRIFT_SMALL) begin
                drift_step = avsfd_pkg::STEP_SMALL;
            end
        end

        sleep_sum = signed'({2'b00, state.sleep})
                  + signed'({{(SB-2){jit_step[3]}}, jit_step})
                  + signed'({{(SB-2){drift_step[3]}}, drift_step});

        if (sleep_sum < 0) begin
            sleep_new = '0;
        end else if (sleep_sum[SB]) begin
            sleep_new = avsfd_pkg::SLEEP_MAX;
        end else begin
            sleep_new = sleep_sum[SB-1:0];
        end

        state_next.latched   = 1'b1;
        state_next.last_tick = now_lo;
        state_next.start_ofs = start_ofs;
        state_next.sleep     = sleep_new;
    end

endmodule

// File: design/avsfd_checker.sv
// ----------------------------------------------------------------------------
// avsfd_checker
// Port-level checks for the frame delay regulator, bound to the top level.
// ----------------------------------------------------------------------------
module avsfd_checker (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     psel,
    input logic                                     penable,
    input logic                                     pwrite,
    input logic                                     pready,
    input logic                                     s_ready,
    input logic                                     m_valid,
    input logic                                     m_ready,
    input logic [avsfd_pkg::SLEEP_BITS-1:0]         m_sleep_ms
);

    localparam int SB = avsfd_pkg::SLEEP_BITS;

    logic          cfg_wr;
    logic [SB:0]   sleep_wide;

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign sleep_wide = {1'b0, m_sleep_ms};

    // reset empties both word registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("words left in flight after reset");

    // with no result pending the input side always has room
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sleep_ms)))
        else $error("stalled result changed");

    // consecutive results move by at most one jitter and one large drift step
    a_sleep_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ((m_valid && m_ready && !cfg_wr) ##1 (m_valid && !$past(cfg_wr, 2)))
        |-> (({1'b0, $past(m_sleep_ms)} <= sleep_wide + (SB+1)'(4))
             && (sleep_wide <= {1'b0, $past(m_sleep_ms)} + (SB+1)'(4))))
        else $error("sleep value jumped too far between frames");

endmodule

bind av_sync_frame_delay_regulator_core avsfd_checker u_avsfd_checker (.*);

// File: verif/tb_av_sync_frame_delay_regulator_core.sv
// ----------------------------------------------------------------------------
// tb_av_sync_frame_delay_regulator_core
// Self-checking bench for the a/v sync frame delay regulator. Frames go in
// over the s_ channel, and a small scoreboard works out the sleep value that
// each one should produce. Every m_ word is checked against the oldest
// expected sleep. Phases walk through several frame period and a/v offset
// settings, extremes included. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_av_sync_frame_delay_regulator_core;

    localparam int STALL_LIMIT = 300;

    localparam int ABITS = avsfd_pkg::APB_ADDR_BITS;
    localparam int DBITS = avsfd_pkg::APB_DATA_BITS;
    localparam int NBITS = avsfd_pkg::NOW_BITS;
    localparam int TBITS = avsfd_pkg::TIME_BITS;
    localparam int PBITS = avsfd_pkg::PERIOD_BITS;
    localparam int OBITS = avsfd_pkg::OFFSET_BITS;
    localparam int SBITS = avsfd_pkg::SLEEP_BITS;

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ABITS-1:0]          paddr;
    logic [DBITS-1:0]          pwdata;
    logic [DBITS-1:0]          prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic [NBITS-1:0]          s_now_ms;
    logic signed [TBITS-1:0]   s_audio_pts_ms;
    logic signed [TBITS-1:0]   s_video_pts_ms;
    logic                      m_valid;
    logic                      m_ready;
    logic [SBITS-1:0]          m_sleep_ms;

    av_sync_frame_delay_regulator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_ms       (s_now_ms),
        .s_audio_pts_ms (s_audio_pts_ms),
        .s_video_pts_ms (s_video_pts_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sleep_ms     (m_sleep_ms)
    );

    // tracks the regulator state and the sleep values still to come out
    class sleep_scoreboard;
        bit [PBITS-1:0]       period;
        bit [OBITS-1:0]       offset;
        bit [SBITS-1:0]       sleep;
        bit [63:0]            last_tick;
        bit                   latched;
        bit [63:0]            origin_pts;
        bit [63:0]            origin_now;
        bit [SBITS-1:0]       sleep_due[$];
        int                   mismatches;

        function new();
            period     = avsfd_pkg::PERIOD_RESET;
            offset     = '0;
            sleep      = SBITS'(avsfd_pkg::PERIOD_RESET);
            last_tick  = '0;
            latched    = 1'b0;
            origin_pts = '0;
            origin_now = '0;
            mismatches = 0;
        endfunction

        function void load_period(bit [PBITS-1:0] p);
            period = p;
            sleep  = SBITS'(p);
        endfunction

        function void load_offset(bit [OBITS-1:0] o);
            offset = o;
        endfunction

        function int pending();
            return sleep_due.size();
        endfunction

        // low 32 bits read as signed
        function longint cut32(bit [63:0] x);
            return longint'(int'(x[31:0]));
        endfunction

        function void frame_accepted(bit [NBITS-1:0] now_ms,
                                     bit [TBITS-1:0] audio_pts,
                                     bit [TBITS-1:0] video_pts);
            bit [63:0] now64;
            bit [63:0] apts;
            bit [63:0] vpts;
            bit [63:0] off64;
            longint    tick_d;
            longint    drift;
            longint    jitter;
            longint    nxt;
            now64 = {{(64-NBITS){1'b0}}, now_ms};
            apts  = {{(64-TBITS){audio_pts[TBITS-1]}}, audio_pts};
            vpts  = {{(64-TBITS){video_pts[TBITS-1]}}, video_pts};
            off64 = {{(64-OBITS){offset[OBITS-1]}}, offset};

            tick_d    = cut32(now64 - last_tick);
            last_tick = now64;
            if (!latched) begin
                latched    = 1'b1;
                origin_pts = vpts;
                origin_now = now64;
            end

            // audio missing: measure video against the clock since the first frame
            if (apts[63] || apts == 0)
                drift = cut32(origin_pts + now64 - origin_now - vpts - off64);
            else
                drift = cut32(apts - vpts - off64);

            nxt    = longint'(sleep);
            jitter = tick_d - longint'(period);
            if (jitter > 5)
                nxt = nxt - 1;
            if (jitter < -5)
                nxt = nxt + 1;
            if (!vpts[63]) begin
                if (drift > 500)
                    nxt = nxt - 3;
                else if (drift > 50)
                    nxt = nxt - 1;
                else if (drift < -500)
                    nxt = nxt + 3;
                else if (drift < -50)
                    nxt = nxt + 1;
            end
            if (nxt < 0)
                nxt = 0;
            if (nxt > 65535)
                nxt = 65535;
            sleep = nxt[SBITS-1:0];
            sleep_due.push_back(sleep);
        endfunction

        function void sleep_observed(bit [SBITS-1:0] got);
            bit [SBITS-1:0] exp_sleep;
            if (sleep_due.size() == 0) begin
                $display("%0t: unexpected sleep_ms word %0d", $time, got);
                mismatches++;
            end else begin
                exp_sleep = sleep_due.pop_front();
                if (got !== exp_sleep) begin
                    $display("%0t: sleep_ms mismatch, expected %0d, got %0d",
                             $time, exp_sleep, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    sleep_scoreboard sb;

    logic [NBITS-1:0]       cur_now;
    logic [PBITS-1:0]       cur_period;
    logic signed [15:0]     cur_offset;
    bit                     tx_steady;
    bit                     rx_steady;
    int                     idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic send_frame(input logic [NBITS-1:0] now_ms,
                              input logic signed [TBITS-1:0] audio_pts,
                              input logic signed [TBITS-1:0] video_pts);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_now_ms       <= now_ms;
        s_audio_pts_ms <= audio_pts;
        s_video_pts_ms <= video_pts;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.frame_accepted(now_ms, audio_pts, video_pts);
    endtask

    task automatic apb_write(input avsfd_pkg::reg_idx_t idx,
                             input logic [DBITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            avsfd_pkg::REG_FRAME_PERIOD: sb.load_period(data[PBITS-1:0]);
            avsfd_pkg::REG_AV_OFFSET:    sb.load_offset(data[OBITS-1:0]);
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // hold off input until every sleep word is back, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_frame();
        logic [NBITS-1:0]            n;
        logic signed [TBITS-1:0]     a;
        logic signed [TBITS-1:0]     v;
        longint                      drift;
        if ($urandom_range(0, 99) < 80) begin
            // plausible frame: period plus a few ms of jitter, drift near the limits
            cur_now = NBITS'(longint'(cur_now) + longint'(cur_period)
                             + longint'($urandom_range(0, 16)) - 8);
            case ($urandom_range(0, 9))
                0:       drift = 50;
                1:       drift = 51;
                2:       drift = -50;
                3:       drift = -51;
                4:       drift = 500;
                5:       drift = 501;
                6:       drift = -500;
                7:       drift = -501;
                8:       drift = 0;
                default: drift = longint'($urandom_range(0, 2400)) - 1200;
            endcase
            if ($urandom_range(0, 9) < 2) begin
                // audio invalid, drift then comes from the clock
                a = ($urandom_range(0, 1) == 0) ? '0
                    : TBITS'(-longint'($urandom_range(1, 100000)));
                v = TBITS'(longint'(cur_now) - longint'(cur_offset) - drift);
            end else begin
                v = TBITS'(longint'(cur_now) + longint'($urandom_range(0, 2000)) - 1000);
                a = TBITS'(longint'(v) + longint'(cur_offset) + drift);
            end
            if ($urandom_range(0, 19) == 0)
                v = '1;
            n = cur_now;
        end else begin
            n = NBITS'({$urandom(), $urandom()});
            a = TBITS'({$urandom(), $urandom()});
            v = TBITS'({$urandom(), $urandom()});
            case ($urandom_range(0, 7))
                0: a = '0;
                1: a = {1'b1, {(TBITS-1){1'b0}}};
                2: v = '1;
                3: v = {1'b0, {(TBITS-1){1'b1}}};
                4: n = '1;
                5: n = '0;
                default: ;
            endcase
        end
        send_frame(n, a, v);
    endtask

    // result side: random stall before each word, steady stretches too
    initial begin
        int stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.sleep_observed(m_sleep_ms);
    end

    // watchdog on cycles with no word moving anywhere
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)
                || (psel === 1'b1 && penable === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_now_ms       = '0;
        s_audio_pts_ms = '0;
        s_video_pts_ms = '0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        cur_period     = avsfd_pkg::PERIOD_RESET;
        cur_offset     = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: period 40, offset 0; first frame latches the start point
        send_frame(47'd1000, 48'sd1000, 48'sd1000);
        send_frame(47'd1040, 48'sd1080, 48'sd1040);
        send_frame(47'd1085, 48'sd1136, 48'sd1085);
        send_frame(47'd1131, 48'sd1631, 48'sd1131);
        send_frame(47'd1171, 48'sd1672, 48'sd1171);
        send_frame(47'd1205, 48'sd1154, 48'sd1205);
        send_frame(47'd1245, 48'sd744,  48'sd1245);
        send_frame(47'd1285, 48'sd785,  48'sd1285);
        send_frame(47'd1325, 48'sd1275, 48'sd1325);
        send_frame(47'd1365, 48'sd5000, -48'sd1);
        send_frame(47'd1405, 48'sd0,    48'sd1345);
        send_frame(47'd1445, 48'sh8000_0000_0000, 48'sd2045);
        send_frame(47'd1485, 48'sh7FFF_FFFF_FFFF, 48'sd0);
        send_frame(47'h7FFF_FFFF_FFFF, 48'sd1, 48'sh7FFF_FFFF_FFFF);
        send_frame(47'd0, -48'sd1, 48'sh8000_0000_0000);
        send_frame(47'h7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 48'sh0000_8000_0000);
        send_frame(47'h0000_8000_0000, 48'sh0001_0000_0032, 48'sd0);
        send_frame(47'h2AAA_AAAA_AAAA, 48'sh5555_5555_5555, 48'sh2AAA_AAAA_AAAA);
        drain();

        // start near the top of the clock range so it wraps during the run
        cur_now = 47'h7FFF_FFFF_0000;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin cur_period = 10'd1;    cur_offset = 16'sd0;      end
                1: begin cur_period = 10'd1000; cur_offset = -16'sd32768; end
                2: begin cur_period = 10'd1023; cur_offset = 16'sd32767;  end
                3: begin cur_period = 10'd0;    cur_offset = -16'sd1;     end
                default: begin
                    cur_period = ($urandom_range(0, 4) == 0) ? PBITS'($urandom_range(1, 1000))
                                                             : PBITS'($urandom_range(15, 70));
                    cur_offset = 16'(int'($urandom_range(0, 1200)) - 600);
                end
            endcase
            apb_write(avsfd_pkg::REG_FRAME_PERIOD, {22'($urandom()), cur_period});
            apb_write(avsfd_pkg::REG_AV_OFFSET, {{16{cur_offset[15]}}, cur_offset});
            tx_steady = (ph % 3 == 1);
            rx_steady = (ph % 4 == 2);
            for (int i = 0; i < 108; i++) begin
                random_frame();
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/avsfd_pkg.sv
design/avsfd_step.sv
design/av_sync_frame_delay_regulator_core.sv
design/avsfd_checker.sv
verif/tb_av_sync_frame_delay_regulator_core.sv
